// ===== sv/can_id_timing_value_anomaly_assert.svh =====
// ----------------------------------------------------------------------------
// can_id_timing_value_anomaly_assert.svh
// assertion macros for the can id timing and value anomaly checker
// ----------------------------------------------------------------------------
`ifndef CAN_ID_TIMING_VALUE_ANOMALY_ASSERT_SVH
`define CAN_ID_TIMING_VALUE_ANOMALY_ASSERT_SVH

`ifndef SYNTH

// condition implies consequence in the same cycle
`define CIATVA_ASSERT_NOW(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("assertion failed");

// condition implies consequence in the next cycle
`define CIATVA_ASSERT_NEXT(label, clk, rst, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("assertion failed");

`else

`define CIATVA_ASSERT_NOW(label, clk, rst, cond, cons)
`define CIATVA_ASSERT_NEXT(label, clk, rst, cond, cons)

`endif

`endif

// ===== sv/ciatva_pkg.sv =====
// ----------------------------------------------------------------------------
// ciatva_pkg
// types and constants of the can id timing and value anomaly checker
// ----------------------------------------------------------------------------
package ciatva_pkg;

  localparam int ID_W   = 29;
  localparam int TIME_W = 63;
  localparam int LEN_W  = 4;
  localparam int BYTE_W = 8;
  localparam int GAP_W  = 32;

  localparam int CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_GAP = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_GAP = 8'd1;

  localparam logic [GAP_W-1:0] MIN_GAP_RESET = 32'd1000;
  localparam logic [GAP_W-1:0] MAX_GAP_RESET = 32'd500000;

  localparam logic KIND_TIMING = 1'b0;
  localparam logic KIND_VALUE  = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]   frame_id;
    logic              frame_extended;
    logic [TIME_W-1:0] frame_time_us;
    logic [LEN_W-1:0]  frame_length;
    logic [BYTE_W-1:0] first_byte;
  } frame_t;

  typedef struct packed {
    logic [ID_W-1:0]   alert_id;
    logic              alert_extended;
    logic [TIME_W-1:0] alert_time_us;
    logic              anomaly_kind;
  } alert_t;

  // per-slot record of the previous frame
  typedef struct packed {
    logic [TIME_W-1:0] prior_time;
    logic [LEN_W-1:0]  prior_length;
    logic [BYTE_W-1:0] prior_byte;
  } prior_t;

  typedef enum logic {
    ST_IDLE,
    ST_CHECK
  } state_t;

endpackage

// ===== sv/ciatva_ram.sv =====
// ----------------------------------------------------------------------------
// ciatva_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module ciatva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/can_id_timing_value_anomaly.sv =====
// ----------------------------------------------------------------------------
// can_id_timing_value_anomaly
// per-identifier timing gap and first-byte jump checker for received can frames
// alert path: a frame and its slot's prior record are registered on acceptance,
//   then checked in ST_CHECK, where the alert is registered; a stalled output holds ST_CHECK
// flow: the input stalls from the ram read of the slot's prior record to its
//   write back; a frame that finds no slot is dropped and does not stall it
// reset: clears slot used and prior flags and restores the gap registers;
//   the ram holds no reset state and needs no clearing pass
// ----------------------------------------------------------------------------
`include "can_id_timing_value_anomaly_assert.svh"

module can_id_timing_value_anomaly #(
  parameter int SLOT_COUNT = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                frame_valid,
  output logic                                frame_stall,
  input  ciatva_pkg::frame_t                  frame,
  output logic                                alert_valid,
  input  logic                                alert_stall,
  output ciatva_pkg::alert_t                  alert,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ciatva_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ciatva_pkg::GAP_W-1:0]        cfg_data
);

  localparam int SLOT_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int PRIOR_W = $bits(ciatva_pkg::prior_t);

  ciatva_pkg::state_t state, state_next;

  logic [ciatva_pkg::GAP_W-1:0] min_gap_us;
  logic [ciatva_pkg::GAP_W-1:0] max_gap_us;

  logic [SLOT_COUNT-1:0]       slot_used;
  logic [SLOT_COUNT-1:0]       slot_has_prior;
  logic [ciatva_pkg::ID_W-1:0] slot_ident [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]       slot_ext;

  ciatva_pkg::frame_t frame_q;
  logic [SLOT_W-1:0]  cur_slot;
  logic               prior_ok;

  logic              frame_accept;
  logic              match_any;
  logic [SLOT_W-1:0] match_idx;
  logic              free_any;
  logic [SLOT_W-1:0] free_idx;
  logic              slot_hit;
  logic [SLOT_W-1:0] hit_idx;

  ciatva_pkg::prior_t rd_prior;
  ciatva_pkg::prior_t wr_prior;
  logic [PRIOR_W-1:0] rd_bits;

  logic [ciatva_pkg::TIME_W:0]   gap_full;
  logic                          timing_alert;
  logic [ciatva_pkg::BYTE_W-1:0] byte_diff;
  logic                          value_alert;
  logic                          alert_hit;
  logic                          check_done;

  assign frame_accept = frame_valid && !frame_stall;

  // identifier match over all slots and lowest free slot
  always_comb begin
    match_any = 1'b0;
    match_idx = '0;
    free_any  = 1'b0;
    free_idx  = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (slot_used[i] && slot_ident[i] == frame.frame_id &&
          slot_ext[i] == frame.frame_extended) begin
        match_any = 1'b1;
        match_idx = SLOT_W'(i);
      end
      if (!slot_used[i]) begin
        free_any = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  assign slot_hit = match_any || free_any;
  assign hit_idx  = match_any ? match_idx : free_idx;

  assign rd_prior = ciatva_pkg::prior_t'(rd_bits);

  // timing check on the signed gap, then the first-byte jump
  always_comb begin
    gap_full = {1'b0, frame_q.frame_time_us} - {1'b0, rd_prior.prior_time};
    timing_alert = gap_full[ciatva_pkg::TIME_W] ||
                   (gap_full[ciatva_pkg::TIME_W-1:0] <
                    {{(ciatva_pkg::TIME_W - ciatva_pkg::GAP_W){1'b0}}, min_gap_us}) ||
                   (gap_full[ciatva_pkg::TIME_W-1:0] >
                    {{(ciatva_pkg::TIME_W - ciatva_pkg::GAP_W){1'b0}}, max_gap_us});
    byte_diff = (frame_q.first_byte >= rd_prior.prior_byte) ?
                (frame_q.first_byte - rd_prior.prior_byte) :
                (rd_prior.prior_byte - frame_q.first_byte);
    value_alert = !timing_alert &&
                  (frame_q.frame_length != '0) &&
                  (rd_prior.prior_length != '0) &&
                  (rd_prior.prior_byte != '0) &&
                  ({byte_diff, 1'b0} > {1'b0, rd_prior.prior_byte});
    alert_hit  = prior_ok && (timing_alert || value_alert);
    check_done = !alert_hit || !alert_valid || !alert_stall;
  end

  assign wr_prior.prior_time   = frame_q.frame_time_us;
  assign wr_prior.prior_length = frame_q.frame_length;
  assign wr_prior.prior_byte   = frame_q.first_byte;

  ciatva_ram #(
    .WIDTH (PRIOR_W),
    .DEPTH (SLOT_COUNT)
  ) u_prior_ram (
    .clk   (clk),
    .we    (state == ciatva_pkg::ST_CHECK && check_done),
    .waddr (cur_slot),
    .wdata (wr_prior),
    .re    (frame_accept),
    .raddr (hit_idx),
    .rdata (rd_bits)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ciatva_pkg::ST_IDLE: begin
        if (frame_accept && slot_hit) begin
          state_next = ciatva_pkg::ST_CHECK;
        end
      end
      ciatva_pkg::ST_CHECK: begin
        if (check_done) begin
          state_next = ciatva_pkg::ST_IDLE;
        end
      end
      default: state_next = ciatva_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    case (state)
      ciatva_pkg::ST_IDLE:  frame_stall = rst;
      ciatva_pkg::ST_CHECK: frame_stall = 1'b1;
      default:              frame_stall = 1'b1;
    endcase
    cfg_ready = !rst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ciatva_pkg::ST_IDLE;
      min_gap_us     <= ciatva_pkg::MIN_GAP_RESET;
      max_gap_us     <= ciatva_pkg::MAX_GAP_RESET;
      slot_used      <= '0;
      slot_has_prior <= '0;
      alert_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ciatva_pkg::CFG_MIN_GAP: min_gap_us <= cfg_data;
          ciatva_pkg::CFG_MAX_GAP: max_gap_us <= cfg_data;
          default: ;
        endcase
      end
      if (frame_accept && !match_any && free_any) begin
        slot_used[free_idx]      <= 1'b1;
        slot_has_prior[free_idx] <= 1'b0;
      end
      if (state == ciatva_pkg::ST_CHECK && check_done) begin
        slot_has_prior[cur_slot] <= 1'b1;
      end
      if (state == ciatva_pkg::ST_CHECK && check_done && alert_hit) begin
        alert_valid <= 1'b1;
      end else if (alert_valid && !alert_stall) begin
        alert_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (frame_accept) begin
      frame_q  <= frame;
      cur_slot <= hit_idx;
      prior_ok <= match_any && slot_has_prior[match_idx];
    end
    if (frame_accept && !match_any && free_any) begin
      slot_ident[free_idx] <= frame.frame_id;
      slot_ext[free_idx]   <= frame.frame_extended;
    end
    if (state == ciatva_pkg::ST_CHECK && check_done && alert_hit) begin
      alert.alert_id       <= frame_q.frame_id;
      alert.alert_extended <= frame_q.frame_extended;
      alert.alert_time_us  <= frame_q.frame_time_us;
      alert.anomaly_kind   <= timing_alert ? ciatva_pkg::KIND_TIMING
                                           : ciatva_pkg::KIND_VALUE;
    end
  end

  `CIATVA_ASSERT_NEXT(a_hit_goes_check, clk, rst, frame_accept && slot_hit,
    state == ciatva_pkg::ST_CHECK)
  `CIATVA_ASSERT_NOW(a_alert_from_check, clk, rst, $rose(alert_valid),
    $past(state == ciatva_pkg::ST_CHECK))
  `CIATVA_ASSERT_NEXT(a_slots_never_freed, clk, rst, 1'b1,
    $countones(slot_used) >= $past($countones(slot_used)))
  `CIATVA_ASSERT_NOW(a_prior_needs_used, clk, rst, 1'b1,
    (slot_has_prior & ~slot_used) == '0)

endmodule

// ===== tb/tb_can_id_timing_value_anomaly.sv =====
// ----------------------------------------------------------------------------
// tb_can_id_timing_value_anomaly
// self-checking bench for the can id timing and value anomaly checker
//
// a short table of directed frames is sent first: gap boundaries, negative
// gaps, first-byte jumps, zero lengths and bytes, and both identifier forms.
// random traffic follows from a pool of identifiers, sized so that the slot
// table fills up and later identifiers are dropped. the gap registers are
// reprogrammed between phases, extremes included. every alert is checked
// field by field against the directed row's outcome or a local model of the slots.
// ----------------------------------------------------------------------------
module tb_can_id_timing_value_anomaly;

  localparam int SLOTS         = 32;
  localparam int POOL          = 34;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int RUN_LIMIT     = 2000000;

  localparam logic [ciatva_pkg::CFG_INDEX_W-1:0] CFG_FIRST_UNUSED = 8'd2;
  localparam logic [ciatva_pkg::CFG_INDEX_W-1:0] CFG_LAST_INDEX   = 8'hFF;
  localparam logic [ciatva_pkg::TIME_W-1:0]      TIME_TOP         =
    {ciatva_pkg::TIME_W{1'b1}};

  typedef enum {
    EXP_NONE,
    EXP_TIMING,
    EXP_VALUE,
    EXP_MODEL
  } outcome_t;

  typedef struct {
    logic [ciatva_pkg::ID_W-1:0]   id;
    logic                          ext;
    logic [ciatva_pkg::TIME_W-1:0] stamp;
    logic [ciatva_pkg::LEN_W-1:0]  len;
    logic [ciatva_pkg::BYTE_W-1:0] data;
    outcome_t                      want;
  } frame_row_t;

  logic                               clk         = 1'b0;
  logic                               rst         = 1'b1;
  logic                               frame_valid = 1'b0;
  logic                               frame_stall;
  ciatva_pkg::frame_t                 frame       = '0;
  logic                               alert_valid;
  logic                               alert_stall = 1'b0;
  ciatva_pkg::alert_t                 alert;
  logic                               cfg_valid   = 1'b0;
  logic                               cfg_ready;
  logic [ciatva_pkg::CFG_INDEX_W-1:0] cfg_index   = '0;
  logic [ciatva_pkg::GAP_W-1:0]       cfg_data    = '0;

  // model of the block
  logic [ciatva_pkg::GAP_W-1:0] min_gap;
  logic [ciatva_pkg::GAP_W-1:0] max_gap;
  logic                         slot_used [SLOTS];
  logic [ciatva_pkg::ID_W-1:0]  slot_id   [SLOTS];
  logic                         slot_ext  [SLOTS];
  logic                         slot_seen [SLOTS];
  ciatva_pkg::prior_t           slot_prior[SLOTS];
  ciatva_pkg::alert_t           alerts_due[$];

  // traffic generator state
  logic [ciatva_pkg::ID_W-1:0]   pool_id  [POOL];
  logic                          pool_ext [POOL];
  logic [ciatva_pkg::TIME_W-1:0] gen_time [POOL];
  logic [ciatva_pkg::BYTE_W-1:0] gen_byte [POOL];

  int                 idle_pct   = 21;
  bit                 hold_req   = 1'b0;
  int                 hold_left  = 0;
  int                 fail_count = 0;
  ciatva_pkg::alert_t due;

  frame_row_t frame_rows [0:20] = '{
    '{29'h0,        1'b0, 63'd0,       4'd8,  8'h0A, EXP_NONE},
    '{29'h0,        1'b0, 63'd1000,    4'd8,  8'h0F, EXP_NONE},
    '{29'h0,        1'b0, 63'd501000,  4'd8,  8'h10, EXP_NONE},
    '{29'h0,        1'b0, 63'd501999,  4'd8,  8'h10, EXP_TIMING},
    '{29'h0,        1'b0, 63'd1002000, 4'd8,  8'h10, EXP_TIMING},
    '{29'h0,        1'b0, 63'd1001999, 4'd8,  8'h10, EXP_TIMING},
    '{29'h0,        1'b0, 63'd1011999, 4'd8,  8'h19, EXP_VALUE},
    '{29'h0,        1'b0, 63'd1021999, 4'd8,  8'h00, EXP_VALUE},
    '{29'h0,        1'b0, 63'd1031999, 4'd8,  8'hFF, EXP_NONE},
    '{29'h0,        1'b0, 63'd1041999, 4'd0,  8'h00, EXP_NONE},
    '{29'h0,        1'b0, 63'd1051999, 4'd8,  8'hFF, EXP_NONE},
    '{29'h0,        1'b0, 63'd1061999, 4'd15, 8'h00, EXP_VALUE},
    '{29'h0,        1'b1, TIME_TOP,    4'd8,  8'h80, EXP_NONE},
    '{29'h1FFFFFFF, 1'b1, TIME_TOP,    4'd8,  8'hFF, EXP_NONE},
    '{29'h1FFFFFFF, 1'b1, TIME_TOP,    4'd8,  8'hFF, EXP_TIMING},
    '{29'h0,        1'b1, 63'd0,       4'd8,  8'h80, EXP_TIMING},
    '{29'h7FF,      1'b0, 63'd5000,    4'd1,  8'h01, EXP_MODEL},
    '{29'h7FF,      1'b0, 63'd6000,    4'd1,  8'h02, EXP_VALUE},
    '{29'h7FF,      1'b0, 63'd7000,    4'd1,  8'h01, EXP_MODEL},
    '{29'h7FF,      1'b0, 63'd7600,    4'd8,  8'hC8, EXP_TIMING},
    '{29'h7FF,      1'b0, 63'd8600,    4'd8,  8'h01, EXP_MODEL}
  };

  can_id_timing_value_anomaly u_top (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .frame       (frame),
    .alert_valid (alert_valid),
    .alert_stall (alert_stall),
    .alert       (alert),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #5 clk = ~clk;

  // returns 0 when the frame finds no slot and is dropped
  function automatic bit judge_frame(input ciatva_pkg::frame_t f, output bit raised,
                                     output ciatva_pkg::alert_t a);
    int s;
    int pb;
    int diff;
    logic [ciatva_pkg::TIME_W-1:0] gap;
    s = -1;
    raised = 1'b0;
    a = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (s < 0 && slot_used[i] && slot_id[i] == f.frame_id
          && slot_ext[i] == f.frame_extended) begin
        s = i;
      end
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (s < 0 && !slot_used[i]) begin
        slot_used[i] = 1'b1;
        slot_id[i]   = f.frame_id;
        slot_ext[i]  = f.frame_extended;
        slot_seen[i] = 1'b0;
        s = i;
      end
    end
    if (s < 0) begin
      return 1'b0;
    end
    a.alert_id       = f.frame_id;
    a.alert_extended = f.frame_extended;
    a.alert_time_us  = f.frame_time_us;
    a.anomaly_kind   = ciatva_pkg::KIND_TIMING;
    if (slot_seen[s]) begin
      // a timestamp going backwards is a negative gap
      if (f.frame_time_us < slot_prior[s].prior_time) begin
        raised = 1'b1;
      end else begin
        gap = f.frame_time_us - slot_prior[s].prior_time;
        if (gap < min_gap || gap > max_gap) begin
          raised = 1'b1;
        end
      end
      if (!raised && f.frame_length != 0 && slot_prior[s].prior_length != 0
          && slot_prior[s].prior_byte != 0) begin
        pb = slot_prior[s].prior_byte;
        diff = int'(f.first_byte) - pb;
        if (diff < 0) begin
          diff = -diff;
        end
        if (2 * diff > pb) begin
          raised = 1'b1;
          a.anomaly_kind = ciatva_pkg::KIND_VALUE;
        end
      end
    end
    slot_prior[s].prior_time   = f.frame_time_us;
    slot_prior[s].prior_length = f.frame_length;
    slot_prior[s].prior_byte   = f.first_byte;
    slot_seen[s] = 1'b1;
    return 1'b1;
  endfunction

  task automatic sender_gap();
    if ($urandom_range(0, 99) < idle_pct) begin
      frame_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic send_frame(input ciatva_pkg::frame_t f, input outcome_t want,
                            output bit matched);
    bit                 raised;
    ciatva_pkg::alert_t a;
    frame       <= f;
    frame_valid <= 1'b1;
    @(posedge clk);
    while (frame_stall) @(posedge clk);
    matched = judge_frame(f, raised, a);
    case (want)
      EXP_MODEL: begin
        if (raised) alerts_due.push_back(a);
      end
      EXP_TIMING: begin
        alerts_due.push_back(ciatva_pkg::alert_t'{f.frame_id, f.frame_extended,
                                                  f.frame_time_us,
                                                  ciatva_pkg::KIND_TIMING});
      end
      EXP_VALUE: begin
        alerts_due.push_back(ciatva_pkg::alert_t'{f.frame_id, f.frame_extended,
                                                  f.frame_time_us,
                                                  ciatva_pkg::KIND_VALUE});
      end
      default: ;
    endcase
  endtask

  // wait for every alert plus the tail of a dropped or quiet frame
  task automatic settle();
    frame_valid <= 1'b0;
    while (alerts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ciatva_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [ciatva_pkg::GAP_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == ciatva_pkg::CFG_MIN_GAP) begin
      min_gap = value;
    end else if (idx == ciatva_pkg::CFG_MAX_GAP) begin
      max_gap = value;
    end
  endtask

  task automatic reprogram(input logic [ciatva_pkg::GAP_W-1:0] lo,
                           input logic [ciatva_pkg::GAP_W-1:0] hi);
    settle();
    write_reg(ciatva_pkg::CFG_MIN_GAP, lo);
    write_reg(ciatva_pkg::CFG_MAX_GAP, hi);
    // unmapped index, must be ignored
    write_reg(ciatva_pkg::CFG_INDEX_W'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_INDEX)),
              $urandom);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_traffic(input int want);
    int                 done;
    int                 k;
    int                 r;
    bit                 matched;
    ciatva_pkg::frame_t f;
    logic [63:0]        span;
    logic [63:0]        gap;
    logic [63:0]        stamp;
    logic [63:0]        wide;
    done = 0;
    while (done < want) begin
      k = $urandom_range(0, POOL - 1);
      wide = {$urandom, $urandom};
      r = $urandom_range(0, 99);
      if (r < 55) begin
        if (min_gap <= max_gap) begin
          span = {32'd0, max_gap} - {32'd0, min_gap} + 64'd1;
          gap = {32'd0, min_gap} + (wide % span);
        end else begin
          gap = {32'd0, $urandom};
        end
        stamp = {1'b0, gen_time[k]} + gap;
      end else if (r < 70) begin
        case ($urandom_range(0, 3))
          0: gap = {32'd0, min_gap};
          1: gap = {32'd0, max_gap};
          2: gap = {32'd0, min_gap} - 64'd1;
          default: gap = {32'd0, max_gap} + 64'd1;
        endcase
        stamp = {1'b0, gen_time[k]} + gap;
      end else if (r < 80) begin
        stamp = {1'b0, gen_time[k]} + {32'd0, $urandom_range(0, min_gap)};
      end else if (r < 90) begin
        stamp = {1'b0, gen_time[k]} - {32'd0, $urandom_range(1, 100000)};
      end else begin
        stamp = wide;
      end
      f.frame_id       = pool_id[k];
      f.frame_extended = pool_ext[k];
      f.frame_time_us  = stamp[ciatva_pkg::TIME_W-1:0];
      r = $urandom_range(0, 9);
      f.frame_length = (r == 0) ? '0
                     : (r == 1) ? ciatva_pkg::LEN_W'($urandom_range(0, 15))
                                : ciatva_pkg::LEN_W'($urandom_range(1, 8));
      r = $urandom_range(0, 9);
      if (r < 5) begin
        f.first_byte = gen_byte[k] + ciatva_pkg::BYTE_W'($urandom_range(0, 24))
                       - ciatva_pkg::BYTE_W'(12);
      end else if (r < 8) begin
        f.first_byte = ciatva_pkg::BYTE_W'($urandom);
      end else if (r == 8) begin
        f.first_byte = '0;
      end else begin
        f.first_byte = '1;
      end
      // a little noise from identifiers outside the pool
      if ($urandom_range(0, 99) < 2) begin
        f.frame_id       = ciatva_pkg::ID_W'($urandom);
        f.frame_extended = 1'($urandom_range(0, 1));
      end else begin
        gen_time[k] = f.frame_time_us;
        gen_byte[k] = f.first_byte;
      end
      sender_gap();
      send_frame(f, EXP_MODEL, matched);
      if (matched) done++;
    end
  endtask

  // alert side: stall and check
  always @(posedge clk) begin
    if (!rst && alert_valid && !alert_stall) begin
      if (alerts_due.size() == 0) begin
        $error("alert with nothing pending: id %h time %h", alert.alert_id,
               alert.alert_time_us);
        fail_count++;
      end else begin
        due = alerts_due.pop_front();
        if (alert.alert_id !== due.alert_id) begin
          $error("alert_id expected %h actual %h", due.alert_id, alert.alert_id);
          fail_count++;
        end
        if (alert.alert_extended !== due.alert_extended) begin
          $error("alert_extended expected %b actual %b", due.alert_extended,
                 alert.alert_extended);
          fail_count++;
        end
        if (alert.alert_time_us !== due.alert_time_us) begin
          $error("alert_time_us expected %h actual %h", due.alert_time_us,
                 alert.alert_time_us);
          fail_count++;
        end
        if (alert.anomaly_kind !== due.anomaly_kind) begin
          $error("anomaly_kind expected %b actual %b", due.anomaly_kind,
                 alert.anomaly_kind);
          fail_count++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      alert_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
      alert_stall <= 1'b1;
    end else begin
      alert_stall <= ($urandom_range(0, 99) < idle_pct);
    end
  end

  initial begin
    #(RUN_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    bit                 matched;
    ciatva_pkg::frame_t f;
    min_gap = ciatva_pkg::MIN_GAP_RESET;
    max_gap = ciatva_pkg::MAX_GAP_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      slot_used[i] = 1'b0;
      slot_seen[i] = 1'b0;
      slot_id[i]   = '0;
      slot_ext[i]  = 1'b0;
      slot_prior[i] = '0;
    end
    // first pool entries reuse the directed identifiers
    pool_id[0] = 29'h0;        pool_ext[0] = 1'b0;
    pool_id[1] = 29'h0;        pool_ext[1] = 1'b1;
    pool_id[2] = 29'h1FFFFFFF; pool_ext[2] = 1'b1;
    pool_id[3] = 29'h7FF;      pool_ext[3] = 1'b0;
    for (int i = 4; i < POOL; i++) begin
      pool_ext[i] = 1'($urandom_range(0, 1));
      pool_id[i]  = pool_ext[i] ? ciatva_pkg::ID_W'($urandom)
                                : ciatva_pkg::ID_W'($urandom_range(0, 11'h7FF));
    end
    for (int i = 0; i < POOL; i++) begin
      gen_time[i] = ciatva_pkg::TIME_W'({$urandom, $urandom});
      gen_byte[i] = ciatva_pkg::BYTE_W'($urandom);
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (frame_rows[i]) begin
      f.frame_id       = frame_rows[i].id;
      f.frame_extended = frame_rows[i].ext;
      f.frame_time_us  = frame_rows[i].stamp;
      f.frame_length   = frame_rows[i].len;
      f.first_byte     = frame_rows[i].data;
      sender_gap();
      send_frame(f, frame_rows[i].want, matched);
    end

    reprogram('0, '1);
    random_traffic(110);

    // long receiver hold-off while frames keep coming
    reprogram(32'd100, 32'd5000);
    hold_req = 1'b1;
    random_traffic(110);

    reprogram('1, '1);
    random_traffic(55);
    settle();
    random_traffic(55);

    begin
      logic [ciatva_pkg::GAP_W-1:0] same;
      same = $urandom_range(0, 20000);
      reprogram(same, same);
    end
    idle_pct = 0;
    random_traffic(110);
    idle_pct = 21;

    reprogram($urandom, $urandom);
    random_traffic(110);

    reprogram(ciatva_pkg::MIN_GAP_RESET, ciatva_pkg::MAX_GAP_RESET);
    random_traffic(110);

    settle();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/ciatva_pkg.sv
sv/ciatva_ram.sv
sv/can_id_timing_value_anomaly.sv
tb/tb_can_id_timing_value_anomaly.sv
